@@ sv/pbts_pkg.sv @@
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared widths, operation codes and status codes of the bitmap priority
// thread scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package pbts_pkg;

    // fixed field widths
    localparam int OP_W     = 2;
    localparam int PRIO_W   = 6;
    localparam int TICKS_W  = 32;
    localparam int STATUS_W = 3;
    localparam int MASK_W   = 32;

    // parameter defaults
    localparam int NUM_PRIO_DEF     = 32;
    localparam int TIMEOUT_BITS_DEF = 32;

    // operation codes
    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_SCHED = 2'd1;
    localparam logic [OP_W-1:0] OP_DELAY = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_TAKEN = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_IDLE  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ZERO  = 3'd4;

endpackage

`default_nettype wire

@@ sv/pbts_ram.sv @@
// ----------------------------------------------------------------------------
// pbts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ sv/priority_bitmap_thread_scheduler.sv @@
// ----------------------------------------------------------------------------
// priority_bitmap_thread_scheduler
// Bitmap priority scheduler with per-priority tick delays.
//
//   channel   direction  handshake            payload
//   command   in         start / busy         i_op, i_prio, i_ticks
//   result    out        o_valid (1 cycle)    o_next_prio, o_switch_needed,
//                                             o_status, o_ready_out,
//                                             o_delayed_out
//
// start and error items: result registered in the cycle after acceptance.
// schedule and delay: a downward scan of the ready mask, one priority per
//   cycle, then the registered result.
// tick: one timeout counter per cycle through the RAM read port and one
//   shared decrementer.
// busy is high from the cycle after acceptance until the result strobe rises.
// synchronous active-low reset clears masks and current priority; the
//   counter RAM is not cleared. results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_thread_scheduler
    import pbts_pkg::*;
#(
    parameter int NUM_PRIO     = NUM_PRIO_DEF,
    parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_op,
    input  wire logic [PRIO_W-1:0]   i_prio,
    input  wire logic [TICKS_W-1:0]  i_ticks,
    output logic                     o_valid,
    output logic [PRIO_W-1:0]        o_next_prio,
    output logic                     o_switch_needed,
    output logic [STATUS_W-1:0]      o_status,
    output logic [MASK_W-1:0]        o_ready_out,
    output logic [MASK_W-1:0]        o_delayed_out
);

    localparam int IW  = $clog2(NUM_PRIO);
    localparam int RIW = $clog2(NUM_PRIO + 1);
    localparam logic [TICKS_W-1:0] TMAX =
        TICKS_W'((64'd1 << TIMEOUT_BITS) - 64'd1);
    localparam logic [PRIO_W-1:0] PRIO_TOP = PRIO_W'(NUM_PRIO);
    localparam logic [IW-1:0] IDX_TOP = IW'(NUM_PRIO - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TICK = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;
    logic [NUM_PRIO:0]   r_reg, n_reg;
    logic [NUM_PRIO-1:0] r_ready, n_ready;
    logic [NUM_PRIO-1:0] r_delayed, n_delayed;
    logic [PRIO_W-1:0]   r_cur, n_cur;

    logic                n_valid;
    logic [PRIO_W-1:0]   n_next_prio;
    logic                n_switch;
    logic [STATUS_W-1:0] n_status;

    // counter RAM port
    logic                    ram_we;
    logic [IW-1:0]           ram_waddr;
    logic [TIMEOUT_BITS-1:0] ram_wdata;
    logic [IW-1:0]           ram_raddr;
    logic [TIMEOUT_BITS-1:0] ram_rdata;

    logic [PRIO_W-1:0]       prio_m1;
    logic [PRIO_W-1:0]       cur_m1;
    logic [TIMEOUT_BITS-1:0] ticks_sat;
    logic [TIMEOUT_BITS-1:0] cnt_dec;
    logic                    cnt_expire;
    logic [PRIO_W-1:0]       scan_prio;
    logic [NUM_PRIO-1:0]     cur_bit;
    logic [NUM_PRIO-1:0]     idx_bit;

    pbts_ram #(
        .WIDTH  (TIMEOUT_BITS),
        .DEPTH  (NUM_PRIO),
        .ADDR_W (IW)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy = (r_state != S_IDLE);

    assign prio_m1   = i_prio - PRIO_W'(1);
    assign cur_m1    = r_cur - PRIO_W'(1);
    assign ticks_sat = (i_ticks > TMAX) ? {TIMEOUT_BITS{1'b1}}
                                        : i_ticks[TIMEOUT_BITS-1:0];
    assign cur_bit   = NUM_PRIO'(1) << cur_m1[IW-1:0];
    assign idx_bit   = NUM_PRIO'(1) << r_idx;
    assign scan_prio = PRIO_W'(r_idx) + PRIO_W'(1);

    // shared decrementer, saturating at zero
    assign cnt_dec    = (ram_rdata == '0) ? '0 : ram_rdata - TIMEOUT_BITS'(1);
    assign cnt_expire = (cnt_dec == '0);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_reg       = r_reg;
        n_ready     = r_ready;
        n_delayed   = r_delayed;
        n_cur       = r_cur;
        n_valid     = 1'b0;
        n_next_prio = r_cur;
        n_switch    = 1'b0;
        n_status    = STAT_OK;
        ram_we      = 1'b0;
        ram_waddr   = cur_m1[IW-1:0];
        ram_wdata   = ticks_sat;
        ram_raddr   = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_START: begin
                            n_valid = 1'b1;
                            if (i_prio > PRIO_TOP) begin
                                n_status = STAT_RANGE;
                            end else if (r_reg[i_prio[RIW-1:0]]) begin
                                n_status = STAT_TAKEN;
                            end else begin
                                n_reg[i_prio[RIW-1:0]] = 1'b1;
                                if (i_prio != '0) begin
                                    n_ready[prio_m1[IW-1:0]] = 1'b1;
                                end
                            end
                        end
                        OP_SCHED: begin
                            n_idx   = IDX_TOP;
                            n_state = S_SCAN;
                        end
                        OP_DELAY: begin
                            if (r_cur == '0 || r_cur > PRIO_TOP) begin
                                n_valid  = 1'b1;
                                n_status = STAT_IDLE;
                            end else if (i_ticks == '0) begin
                                n_valid  = 1'b1;
                                n_status = STAT_ZERO;
                            end else begin
                                ram_we    = 1'b1;
                                n_ready   = r_ready & ~cur_bit;
                                n_delayed = r_delayed | cur_bit;
                                n_idx     = IDX_TOP;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            // tick: prefetch counter 0
                            ram_raddr = '0;
                            n_idx     = '0;
                            n_state   = S_TICK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_ready[r_idx]) begin
                    n_cur       = scan_prio;
                    n_next_prio = scan_prio;
                    n_switch    = (scan_prio != r_cur);
                    n_valid     = 1'b1;
                    n_state     = S_IDLE;
                end else if (r_idx == '0) begin
                    n_cur       = '0;
                    n_next_prio = '0;
                    n_switch    = (r_cur != '0);
                    n_valid     = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx - IW'(1);
                end
            end
            S_TICK: begin
                ram_raddr = r_idx + IW'(1);
                ram_waddr = r_idx;
                ram_wdata = cnt_dec;
                if (r_delayed[r_idx]) begin
                    ram_we = 1'b1;
                    if (cnt_expire) begin
                        n_ready   = r_ready | idx_bit;
                        n_delayed = r_delayed & ~idx_bit;
                    end
                end
                if (r_idx == IDX_TOP) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_reg     <= '0;
            r_ready   <= '0;
            r_delayed <= '0;
            r_cur     <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_reg     <= n_reg;
            r_ready   <= n_ready;
            r_delayed <= n_delayed;
            r_cur     <= n_cur;
            o_valid   <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            o_next_prio     <= n_next_prio;
            o_switch_needed <= n_switch;
            o_status        <= n_status;
            o_ready_out     <= MASK_W'(n_ready);
            o_delayed_out   <= MASK_W'(n_delayed);
        end
    end

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while sequencer still busy");

    a_ready_delayed_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_delayed) == '0)
        else $error("priority both ready and delayed");

    a_delayed_registered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_delayed & ~r_reg[NUM_PRIO:1]) == '0)
        else $error("delayed priority was never registered");

    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= PRIO_TOP)
        else $error("current priority out of range");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_TICK || i_op == OP_SCHED)) |=> busy)
        else $error("multi-cycle item did not start the sequencer");

endmodule

`default_nettype wire
